[rtl/acfc_pkg.sv]
package acfc_pkg;

  // input item: one fetched instruction word and its address
  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] instr_addr;
  } acfc_in_t;

  // result item: flow class, direct target and literal-load reference
  typedef struct packed {
    logic        may_continue;
    logic        jump_indirect;
    logic        jump_direct;
    logic        is_link;
    logic        undefined_op;
    logic [31:0] target_addr;
    logic        data_ref;
    logic        data_ref_byte;
    logic [31:0] data_ref_addr;
  } acfc_out_t;

  // how the literal address is formed from PC+8
  typedef enum logic [1:0] {
    DREF_BASE = 2'd0,
    DREF_ADD  = 2'd1,
    DREF_SUB  = 2'd2
  } acfc_dref_mode_t;

  localparam logic [3:0]  COND_ALWAYS  = 4'he;
  localparam logic [3:0]  REG_PC       = 4'hf;
  localparam logic [31:0] PC_AHEAD     = 32'd8;

  // encoding masks and match patterns, in priority order
  localparam logic [31:0] BX_MASK      = 32'h0fff_fff0;
  localparam logic [31:0] BX_MATCH     = 32'h012f_ff10;
  localparam logic [31:0] SWI_MASK     = 32'h0f00_0000;
  localparam logic [31:0] SWI_MATCH    = 32'h0f00_0000;
  localparam logic [31:0] B_MASK       = 32'h0e00_0000;
  localparam logic [31:0] B_MATCH      = 32'h0a00_0000;
  localparam logic [31:0] MRS_MASK     = 32'h0fbf_0fff;
  localparam logic [31:0] MRS_MATCH    = 32'h010f_0000;
  localparam logic [31:0] MSRR_MASK    = 32'h0fb0_fff0;
  localparam logic [31:0] MSRR_MATCH   = 32'h0120_f000;
  localparam logic [31:0] MSRI_MASK    = 32'h0fb0_f000;
  localparam logic [31:0] MSRI_MATCH   = 32'h0320_f000;
  localparam logic [31:0] MUL_MASK     = 32'h0fc0_00f0;
  localparam logic [31:0] MUL_MATCH    = 32'h0000_0090;
  localparam logic [31:0] MULL_MASK    = 32'h0f80_00f0;
  localparam logic [31:0] MULL_MATCH   = 32'h0080_0090;
  localparam logic [31:0] LS_MASK      = 32'h0c00_0000;
  localparam logic [31:0] LS_MATCH     = 32'h0400_0000;
  localparam logic [31:0] CRT_MASK     = 32'h0f00_0010;
  localparam logic [31:0] CRT_MATCH    = 32'h0e00_0010;
  localparam logic [31:0] SWP_MASK     = 32'h0fb0_0ff0;
  localparam logic [31:0] SWP_MATCH    = 32'h0100_0090;
  localparam logic [31:0] HLS_MASK     = 32'h0e00_0090;
  localparam logic [31:0] HLS_MATCH    = 32'h0000_0090;
  localparam logic [31:0] LSM_MASK     = 32'h0e00_0000;
  localparam logic [31:0] LSM_MATCH    = 32'h0800_0000;
  localparam logic [31:0] DP_MASK      = 32'h0c00_0000;
  localparam logic [31:0] DP_MATCH     = 32'h0000_0000;

  localparam logic [3:0]  OP_MOV       = 4'hd;
  localparam logic [3:0]  OP_MVN       = 4'hf;
  localparam logic [1:0]  OP_TEST_GRP  = 2'b10;

  localparam logic [1:0]  SH_SWP       = 2'd0;
  localparam logic [1:0]  SH_UH        = 2'd1;
  localparam logic [1:0]  SH_SB        = 2'd2;
  localparam logic [1:0]  SH_SH        = 2'd3;

  localparam logic [31:0] LIT_OFF_MASK = 32'h0000_0fff;

endpackage

[rtl/arm_control_flow_classifier.sv]
// channel | ports                          | transfer when
// --------+--------------------------------+------------------------------
// input   | start, busy, in_data           | start high and busy low
// result  | out_valid, out_data            | out_valid high (one cycle)
//
// three register stages: decode, add/rotate, target select
// an input transfer passes through the decode, add/rotate and target-select registers to out_valid
// one word is taken every cycle; busy is always low
// the receiver cannot stall, so valid bits simply shift each cycle
// rst_n (synchronous) clears the valid bits only
module arm_control_flow_classifier
  import acfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  acfc_in_t  in_data,
  output logic      out_valid,
  output acfc_out_t out_data
);

  // ---------------- stage 1: encoding match ----------------
  logic        v1_r;
  logic        cont1_r, ind1_r, dirb1_r, dirm1_r, lnk1_r, und1_r, mvn1_r;
  logic [7:0]  imm1_r;
  logic [3:0]  rot1_r;
  logic [31:0] boff1_r;
  logic [31:0] base1_r;
  logic        dref1_r, dbyte1_r;
  acfc_dref_mode_t dmode1_r;
  logic [11:0] doff1_r;

  logic        cont_nxt, ind_nxt, dirb_nxt, dirm_nxt, lnk_nxt, und_nxt, mvn_nxt;
  logic        pcind_nxt, dref_nxt;
  acfc_dref_mode_t dmode_nxt;

  logic [31:0] w;
  logic [3:0]  rd, rn, op;
  logic        lbit;
  logic [1:0]  sh;

  assign w    = in_data.instr_word;
  assign rd   = w[15:12];
  assign rn   = w[19:16];
  assign op   = w[24:21];
  assign lbit = w[20];
  assign sh   = w[6:5];

  // priority decode of the control-flow class
  always_comb begin
    cont_nxt  = 1'b1;
    ind_nxt   = 1'b0;
    dirb_nxt  = 1'b0;
    dirm_nxt  = 1'b0;
    lnk_nxt   = 1'b0;
    und_nxt   = 1'b0;
    mvn_nxt   = 1'b0;
    pcind_nxt = 1'b0;
    priority if ((w & BX_MASK) == BX_MATCH) begin
      cont_nxt = 1'b0;
      ind_nxt  = 1'b1;
    end else if ((w & SWI_MASK) == SWI_MATCH) begin
      ind_nxt = 1'b1;
    end else if ((w & B_MASK) == B_MATCH) begin
      dirb_nxt = 1'b1;
      // link bit: BL returns, so it continues
      cont_nxt = w[24];
      lnk_nxt  = w[24];
    end else if (((w & MRS_MASK) == MRS_MATCH) || ((w & MSRR_MASK) == MSRR_MATCH) ||
                 ((w & MSRI_MASK) == MSRI_MATCH)) begin
      // status register moves fall through
      cont_nxt = 1'b1;
    end else if ((w & MUL_MASK) == MUL_MATCH) begin
      pcind_nxt = (rn == REG_PC);
    end else if ((w & MULL_MASK) == MULL_MATCH) begin
      pcind_nxt = (rn == REG_PC) || (rd == REG_PC);
    end else if ((w & LS_MASK) == LS_MATCH) begin
      pcind_nxt = lbit && (rd == REG_PC);
    end else if ((w & CRT_MASK) == CRT_MATCH) begin
      pcind_nxt = lbit && (rd == REG_PC);
    end else if ((w & SWP_MASK) == SWP_MATCH) begin
      pcind_nxt = (rd == REG_PC);
    end else if ((w & HLS_MASK) == HLS_MATCH) begin
      unique case (sh)
        SH_UH, SH_SH: pcind_nxt = lbit && (rd == REG_PC);
        SH_SB:        pcind_nxt = (rd == REG_PC);
        SH_SWP:       pcind_nxt = 1'b0;
        default:      pcind_nxt = 1'b0;
      endcase
    end else if ((w & LSM_MASK) == LSM_MATCH) begin
      pcind_nxt = lbit && w[15];
    end else if ((w & DP_MASK) == DP_MATCH) begin
      // compare/test ops do not write rd
      if ((op[3:2] != OP_TEST_GRP) && (rd == REG_PC)) begin
        cont_nxt = 1'b0;
        if (((op == OP_MOV) || (op == OP_MVN)) && w[25]) begin
          dirm_nxt = 1'b1;
          mvn_nxt  = (op == OP_MVN);
        end else begin
          ind_nxt = 1'b1;
        end
      end
    end else begin
      cont_nxt = 1'b0;
      und_nxt  = 1'b1;
    end

    if (pcind_nxt) begin
      cont_nxt = 1'b0;
      ind_nxt  = 1'b1;
    end
    // conditional instructions can always fall through, except undefined
    if (!und_nxt && (w[31:28] != COND_ALWAYS)) begin
      cont_nxt = 1'b1;
    end
  end

  // literal load: LDR/LDRB, immediate offset, base register is pc
  always_comb begin
    dref_nxt = ((w & LS_MASK) == LS_MATCH) && (rn == REG_PC) && !w[25] && lbit;
    priority if (!w[24]) begin
      dmode_nxt = DREF_BASE;
    end else if (w[23]) begin
      dmode_nxt = DREF_ADD;
    end else begin
      dmode_nxt = DREF_SUB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    cont1_r  <= cont_nxt;
    ind1_r   <= ind_nxt;
    dirb1_r  <= dirb_nxt;
    dirm1_r  <= dirm_nxt;
    lnk1_r   <= lnk_nxt;
    und1_r   <= und_nxt;
    mvn1_r   <= mvn_nxt;
    imm1_r   <= w[7:0];
    rot1_r   <= w[11:8];
    boff1_r  <= {{6{w[23]}}, w[23:0], 2'b00};
    base1_r  <= in_data.instr_addr + PC_AHEAD;
    dref1_r  <= dref_nxt;
    dbyte1_r <= dref_nxt && w[22];
    dmode1_r <= dmode_nxt;
    doff1_r  <= w[11:0];
  end

  // ---------------- stage 2: adds and immediate rotate ----------------
  logic        v2_r;
  logic        cont2_r, ind2_r, dirb2_r, dirm2_r, lnk2_r, und2_r;
  logic [31:0] tgtb2_r, tgtm2_r;
  logic        dref2_r, dbyte2_r;
  logic [31:0] daddr2_r;

  logic [4:0]  rot_amt;
  logic [63:0] rot_wide;
  logic [31:0] rot_val;
  logic [31:0] doff_ext;
  logic [31:0] daddr_nxt;

  // rotate right by twice the 4-bit field; zero amount leaves it as is
  assign rot_amt  = {rot1_r, 1'b0};
  assign rot_wide = {24'd0, imm1_r, 24'd0, imm1_r} >> rot_amt;
  assign rot_val  = rot_wide[31:0];
  assign doff_ext = {20'd0, doff1_r};

  always_comb begin
    unique case (dmode1_r)
      DREF_ADD:  daddr_nxt = base1_r + doff_ext;
      DREF_SUB:  daddr_nxt = base1_r - doff_ext;
      DREF_BASE: daddr_nxt = base1_r;
      default:   daddr_nxt = base1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    cont2_r  <= cont1_r;
    ind2_r   <= ind1_r;
    dirb2_r  <= dirb1_r;
    dirm2_r  <= dirm1_r;
    lnk2_r   <= lnk1_r;
    und2_r   <= und1_r;
    tgtb2_r  <= base1_r + boff1_r;
    tgtm2_r  <= mvn1_r ? ~rot_val : rot_val;
    dref2_r  <= dref1_r;
    dbyte2_r <= dbyte1_r;
    daddr2_r <= dref1_r ? daddr_nxt : 32'd0;
  end

  // ---------------- stage 3: target select, output register ----------------
  logic      v3_r;
  acfc_out_t out3_r;
  acfc_out_t out_nxt;

  always_comb begin
    out_nxt.may_continue  = cont2_r;
    out_nxt.jump_indirect = ind2_r;
    out_nxt.jump_direct   = dirb2_r || dirm2_r;
    out_nxt.is_link       = lnk2_r;
    out_nxt.undefined_op  = und2_r;
    // target is zero unless a direct jump was found
    priority if (dirb2_r) begin
      out_nxt.target_addr = tgtb2_r;
    end else if (dirm2_r) begin
      out_nxt.target_addr = tgtm2_r;
    end else begin
      out_nxt.target_addr = 32'd0;
    end
    out_nxt.data_ref      = dref2_r;
    out_nxt.data_ref_byte = dbyte2_r;
    out_nxt.data_ref_addr = daddr2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    out3_r <= out_nxt;
  end

  assign busy      = 1'b0;
  assign out_valid = v3_r;
  assign out_data  = out3_r;

endmodule
